// ===== design/gn2d_pkg.sv =====
// Shared types and constants of the 2D gradient noise evaluator.
package gn2d_pkg;

	// defaults of the top-level parameters
	localparam int GRID_SIDE_DEF = 256;
	localparam int FRAC_BITS_DEF = 16;
	localparam int GRAD_BITS_DEF = 16;

	// fixed field widths on the stream ports
	localparam int CELL_W  = 8;
	localparam int FIELD_W = 16;
	localparam int OUT_W   = 16;

	// s_tdata layout, lowest bit first
	localparam int CX_LSB    = 0;
	localparam int CY_LSB    = 8;
	localparam int FX_LSB    = 16;
	localparam int FY_LSB    = 32;
	localparam int GX_LSB    = 48;
	localparam int GY_LSB    = 64;
	localparam int S_TDATA_W = 80;

	// action codes carried in s_tuser
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_EVAL  = 1'b1;

	// corner dots and blend run in Q.30, range [-4, 4]
	localparam int DOT_FRAC = 30;
	localparam int DOT_W    = 34;
	localparam int ROUND_SH = DOT_FRAC - 15;

	// fade polynomial 6t^5 - 15t^4 + 10t^3
	localparam int FADE_C5 = 6;
	localparam int FADE_C4 = 15;
	localparam int FADE_C3 = 10;

	// pipeline stage count, output register not included
	localparam int NUM_STG = 10;

	typedef struct packed {
		logic [NUM_STG:1] ld;   // stage k register takes a new item this cycle
	} pipe_ctl_t;

endpackage

// ===== design/gn2d_gtab.sv =====
// Gradient table memory: one write port, two registered read ports.
module gn2d_gtab #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [DW-1:0] rdata0,
	output logic [DW-1:0] rdata1
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd0_q;
	logic [DW-1:0] rd1_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re) begin
			rd0_q <= mem_q[raddr0];
			rd1_q <= mem_q[raddr1];
		end
	end

	assign rdata0 = rd0_q;
	assign rdata1 = rd1_q;

endmodule

// ===== design/gn2d_fade.sv =====
// Quintic fade pipeline, stages 2 to 6, one multiply per stage.
module gn2d_fade #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  gn2d_pkg::pipe_ctl_t   ctl,
	input  logic [FRAC_BITS-1:0]  f,
	output logic [FRAC_BITS:0]    u
);

	import gn2d_pkg::*;

	localparam int WW = FRAC_BITS + 5;
	localparam int MW = WW + FRAC_BITS + 1;
	localparam int UW = FRAC_BITS + 1;
	localparam logic signed [WW-1:0] SIX   = WW'(FADE_C5);
	localparam logic signed [WW-1:0] K15   = WW'(FADE_C4 * (2 ** FRAC_BITS));
	localparam logic signed [WW-1:0] K10   = WW'(FADE_C3 * (2 ** FRAC_BITS));
	localparam logic signed [WW-1:0] ONE_T = WW'(2 ** FRAC_BITS);

	logic [FRAC_BITS-1:0] f_s2, f_s3, f_s4, f_s5;
	logic signed [WW-1:0] w0_s2, w1_s3, w2_s4, w3_s5;
	logic [UW-1:0]        u_s6;

	logic signed [WW-1:0] w0_d, w1_d, w2_d, w3_d, w4_d;
	logic signed [MW-1:0] m1, m2, m3, m4;
	logic [UW-1:0]        u_d;

	always_comb begin
		w0_d = WW'($signed({1'b0, f})) * SIX - K15;
		m1   = MW'(w0_s2) * MW'($signed({1'b0, f_s2}));
		w1_d = WW'(m1 >>> FRAC_BITS) + K10;
		m2   = MW'(w1_s3) * MW'($signed({1'b0, f_s3}));
		w2_d = WW'(m2 >>> FRAC_BITS);
		m3   = MW'(w2_s4) * MW'($signed({1'b0, f_s4}));
		w3_d = WW'(m3 >>> FRAC_BITS);
		m4   = MW'(w3_s5) * MW'($signed({1'b0, f_s5}));
		w4_d = WW'(m4 >>> FRAC_BITS);
		// clamp to [0, 1]
		if (w4_d[WW-1])
			u_d = '0;
		else if (w4_d > ONE_T)
			u_d = UW'(ONE_T);
		else
			u_d = UW'(w4_d);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[2]) begin
			f_s2  <= f;
			w0_s2 <= w0_d;
		end
		if (ctl.ld[3]) begin
			f_s3  <= f_s2;
			w1_s3 <= w1_d;
		end
		if (ctl.ld[4]) begin
			f_s4  <= f_s3;
			w2_s4 <= w2_d;
		end
		if (ctl.ld[5]) begin
			f_s5  <= f_s4;
			w3_s5 <= w3_d;
		end
		if (ctl.ld[6])
			u_s6 <= u_d;
	end

	assign u = u_s6;

endmodule

// ===== design/gn2d_corner.sv =====
// One corner dot product, stages 5 and 6, scaled to Q.30.
module gn2d_corner #(
	parameter int FRAC_BITS = 16,
	parameter int GRAD_BITS = 16
) (
	input  logic                                clk,
	input  gn2d_pkg::pipe_ctl_t                 ctl,
	input  logic [2*GRAD_BITS-1:0]              grad,   // gx low, gy high
	input  logic signed [FRAC_BITS:0]           ox,
	input  logic signed [FRAC_BITS:0]           oy,
	output logic signed [gn2d_pkg::DOT_W-1:0]   dot
);

	import gn2d_pkg::*;

	localparam int PW  = GRAD_BITS + FRAC_BITS + 1;
	localparam int SW  = PW + 1;
	localparam int PF  = FRAC_BITS + GRAD_BITS - 2;
	localparam int SHR = (PF >= DOT_FRAC) ? PF - DOT_FRAC : 0;
	localparam int SHL = (PF < DOT_FRAC) ? DOT_FRAC - PF : 0;
	localparam int XW  = SW + SHL;

	logic signed [GRAD_BITS-1:0] gx, gy;
	logic signed [PW-1:0]        px_s5, py_s5;
	logic signed [DOT_W-1:0]     dot_s6;

	logic signed [SW-1:0]    sum;
	logic signed [XW-1:0]    xs_l, xs_r;
	logic signed [DOT_W-1:0] dot_d;

	assign gx = $signed(grad[GRAD_BITS-1:0]);
	assign gy = $signed(grad[2*GRAD_BITS-1:GRAD_BITS]);

	always_comb begin
		sum   = SW'(px_s5) + SW'(py_s5);
		xs_l  = XW'(sum) <<< SHL;
		xs_r  = xs_l >>> SHR;   // floor
		dot_d = DOT_W'(xs_r);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[5]) begin
			px_s5 <= PW'(gx) * PW'(ox);
			py_s5 <= PW'(gy) * PW'(oy);
		end
		if (ctl.ld[6])
			dot_s6 <= dot_d;
	end

	assign dot = dot_s6;

endmodule

// ===== design/gn2d_blend.sv =====
// Bilinear blend of the four corner dots, stages 7 to 10.
module gn2d_blend #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  gn2d_pkg::pipe_ctl_t                ctl,
	input  logic signed [gn2d_pkg::DOT_W-1:0]  d0,
	input  logic signed [gn2d_pkg::DOT_W-1:0]  d1,
	input  logic signed [gn2d_pkg::DOT_W-1:0]  d2,
	input  logic signed [gn2d_pkg::DOT_W-1:0]  d3,
	input  logic [FRAC_BITS:0]                 u,
	input  logic [FRAC_BITS:0]                 v,
	output logic signed [gn2d_pkg::DOT_W-1:0]  n
);

	import gn2d_pkg::*;

	localparam int DW1 = DOT_W + 1;
	localparam int PAW = DW1 + FRAC_BITS + 2;

	logic signed [PAW-1:0]   pa_s7, pb_s7, pn_s9;
	logic signed [DOT_W-1:0] d0_s7, d2_s7, a_s8, b_s8, a_s9, n_s10;
	logic [FRAC_BITS:0]      v_s7, v_s8;

	logic signed [DW1-1:0]   da, db, dn;
	logic signed [DOT_W-1:0] a_d, b_d, n_d;

	always_comb begin
		da  = DW1'(d1) - DW1'(d0);
		db  = DW1'(d3) - DW1'(d2);
		a_d = DOT_W'(DW1'(d0_s7) + DW1'(pa_s7 >>> FRAC_BITS));
		b_d = DOT_W'(DW1'(d2_s7) + DW1'(pb_s7 >>> FRAC_BITS));
		dn  = DW1'(b_s8) - DW1'(a_s8);
		n_d = DOT_W'(DW1'(a_s9) + DW1'(pn_s9 >>> FRAC_BITS));
	end

	always_ff @(posedge clk) begin
		if (ctl.ld[7]) begin
			pa_s7 <= PAW'(da) * PAW'($signed({1'b0, u}));
			pb_s7 <= PAW'(db) * PAW'($signed({1'b0, u}));
			d0_s7 <= d0;
			d2_s7 <= d2;
			v_s7  <= v;
		end
		if (ctl.ld[8]) begin
			a_s8 <= a_d;
			b_s8 <= b_d;
			v_s8 <= v_s7;
		end
		if (ctl.ld[9]) begin
			pn_s9 <= PAW'(dn) * PAW'($signed({1'b0, v_s8}));
			a_s9  <= a_s8;
		end
		if (ctl.ld[10])
			n_s10 <= n_d;
	end

	assign n = n_s10;

endmodule

// ===== design/gradient_noise_2d_eval.sv =====
// Top level of the 2D gradient noise evaluator: stream ports, addressing, table, output.
// Fully pipelined: one item (write or evaluate) is taken every cycle unless m_tready
// back-pressure has filled every stage; an evaluate result shows on m_tdata, and
// a write gives no result. Stages: input, cell reduction, address, table read, corner
// products, corner dots, two blend steps of two stages each, and the output register;
// the fade of both fractions runs alongside in stages 2 to 6. The gradient table
// is held twice, one copy per corner row, each with one write and two read ports, so all
// four corners are read in the same cycle. A write lands in the table as it leaves stage 3
// and every later evaluate sees it. An entry that was never written reads as an unknown
// gradient. Each stage holds its item while the stage after it is full and held, so
// s_tready stays high as long as there is a free slot anywhere ahead.
module gradient_noise_2d_eval #(
	parameter int GRID_SIDE = gn2d_pkg::GRID_SIDE_DEF,
	parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF,
	parameter int GRAD_BITS = gn2d_pkg::GRAD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// cell_x, cell_y, frac_x, frac_y, grad_x, grad_y
	input  logic [gn2d_pkg::S_TDATA_W-1:0]   s_tdata,
	// action
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// noise
	output logic [gn2d_pkg::OUT_W-1:0]       m_tdata
);

	import gn2d_pkg::*;

	localparam int CW    = $clog2(GRID_SIDE);
	localparam int DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int GW    = 2 * GRAD_BITS;
	localparam int FEXT  = (FRAC_BITS > FIELD_W) ? FRAC_BITS : FIELD_W;
	localparam int GEXT  = (GRAD_BITS > FIELD_W) ? GRAD_BITS : FIELD_W;
	localparam int RW    = DOT_W + 1;
	localparam int MOD_N = 2 ** CELL_W;
	localparam logic [CW-1:0] LAST_CELL = CW'(GRID_SIDE - 1);
	localparam logic [AW-1:0] SIDE_A    = AW'(GRID_SIDE);
	localparam logic signed [RW-1:0] RND    = RW'(2 ** (DOT_FRAC - 16));
	localparam logic signed [RW-1:0] SAT_HI = RW'(32767);
	localparam logic signed [RW-1:0] SAT_LO = RW'(-32768);

	pipe_ctl_t ctl;
	logic      out_ld;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic out_vld_q;
	logic [NUM_STG:1] vld_all;

	// stage 1: input register
	logic                 act_s1;
	logic [CELL_W-1:0]    cx_s1, cy_s1;
	logic [FRAC_BITS-1:0] fx_s1, fy_s1;
	logic [GW-1:0]        gw_s1;
	// stage 2: reduced cells
	logic                 act_s2;
	logic [CW-1:0]        col0_s2, col1_s2, row0_s2, row1_s2;
	logic [FRAC_BITS-1:0] fx_s2, fy_s2;
	logic [GW-1:0]        gw_s2;
	// stage 3: table addresses
	logic                 act_s3;
	logic [AW-1:0]        a00_s3, a10_s3, a01_s3, a11_s3;
	logic [FRAC_BITS-1:0] fx_s3, fy_s3;
	logic [GW-1:0]        gw_s3;
	// stage 4: offsets, gradients come out of the table registers
	logic [FRAC_BITS-1:0] fx_s4, fy_s4;
	logic [GW-1:0]        g00, g10, g01, g11;
	logic signed [FRAC_BITS:0] ox0, ox1, oy0, oy1;

	logic [FEXT-1:0] fx_ext, fy_ext;
	logic [GEXT-1:0] gx_ext, gy_ext;
	logic [CW-1:0]   mod_tab [MOD_N];
	logic [CW-1:0]   col0_d, row0_d;
	logic            tab_we;

	logic signed [DOT_W-1:0] d0, d1, d2, d3, n_s10;
	logic [FRAC_BITS:0]      u, v;

	logic signed [RW-1:0] n_rnd, n_sh;
	logic [OUT_W-1:0]     noise_d, noise_q;

	// handshake: a stage loads when it is empty or its item moves on
	assign vld_all = {vld_s10, vld_s9, vld_s8, vld_s7, vld_s6,
	                  vld_s5, vld_s4, vld_s3, vld_s2, vld_s1};
	assign out_ld  = !out_vld_q || m_tready;

	always_comb begin
		ctl.ld[NUM_STG] = !vld_all[NUM_STG] || out_ld;
		for (int k = NUM_STG - 1; k >= 1; k--)
			ctl.ld[k] = !vld_all[k] || ctl.ld[k+1];
	end

	assign s_tready = ctl.ld[1];
	assign m_tvalid = out_vld_q;
	assign m_tdata  = noise_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			vld_s9    <= 1'b0;
			vld_s10   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (ctl.ld[1])  vld_s1  <= s_tvalid;
			if (ctl.ld[2])  vld_s2  <= vld_s1;
			if (ctl.ld[3])  vld_s3  <= vld_s2;
			// writes retire once they reach the table
			if (ctl.ld[4])  vld_s4  <= vld_s3 && (act_s3 == ACT_EVAL);
			if (ctl.ld[5])  vld_s5  <= vld_s4;
			if (ctl.ld[6])  vld_s6  <= vld_s5;
			if (ctl.ld[7])  vld_s7  <= vld_s6;
			if (ctl.ld[8])  vld_s8  <= vld_s7;
			if (ctl.ld[9])  vld_s9  <= vld_s8;
			if (ctl.ld[10]) vld_s10 <= vld_s9;
			if (out_ld)     out_vld_q <= vld_s10;
		end
	end

	// field extraction; fractions keep their low FRAC_BITS, gradients their low GRAD_BITS
	assign fx_ext = FEXT'(s_tdata[FX_LSB +: FIELD_W]);
	assign fy_ext = FEXT'(s_tdata[FY_LSB +: FIELD_W]);
	assign gx_ext = GEXT'(s_tdata[GX_LSB +: FIELD_W]);
	assign gy_ext = GEXT'(s_tdata[GY_LSB +: FIELD_W]);

	// cell mod GRID_SIDE as a constant lookup over every cell value
	for (genvar k = 0; k < MOD_N; k++) begin : g_mod_tab
		assign mod_tab[k] = CW'(k % GRID_SIDE);
	end

	assign col0_d = mod_tab[cx_s1];
	assign row0_d = mod_tab[cy_s1];

	// offsets: f and f - 1 in FRAC_BITS+1 two's complement
	assign ox0 = $signed({1'b0, fx_s4});
	assign ox1 = $signed({1'b1, fx_s4});
	assign oy0 = $signed({1'b0, fy_s4});
	assign oy1 = $signed({1'b1, fy_s4});

	always_ff @(posedge clk) begin
		if (ctl.ld[1]) begin
			act_s1 <= s_tuser;
			cx_s1  <= s_tdata[CX_LSB +: CELL_W];
			cy_s1  <= s_tdata[CY_LSB +: CELL_W];
			fx_s1  <= fx_ext[FRAC_BITS-1:0];
			fy_s1  <= fy_ext[FRAC_BITS-1:0];
			gw_s1  <= {gy_ext[GRAD_BITS-1:0], gx_ext[GRAD_BITS-1:0]};
		end
		if (ctl.ld[2]) begin
			act_s2  <= act_s1;
			col0_s2 <= col0_d;
			row0_s2 <= row0_d;
			col1_s2 <= (col0_d == LAST_CELL) ? '0 : CW'(col0_d + 1'b1);
			row1_s2 <= (row0_d == LAST_CELL) ? '0 : CW'(row0_d + 1'b1);
			fx_s2   <= fx_s1;
			fy_s2   <= fy_s1;
			gw_s2   <= gw_s1;
		end
		if (ctl.ld[3]) begin
			act_s3 <= act_s2;
			a00_s3 <= AW'(AW'(row0_s2) * SIDE_A + AW'(col0_s2));
			a10_s3 <= AW'(AW'(row0_s2) * SIDE_A + AW'(col1_s2));
			a01_s3 <= AW'(AW'(row1_s2) * SIDE_A + AW'(col0_s2));
			a11_s3 <= AW'(AW'(row1_s2) * SIDE_A + AW'(col1_s2));
			fx_s3  <= fx_s2;
			fy_s3  <= fy_s2;
			gw_s3  <= gw_s2;
		end
		if (ctl.ld[4]) begin
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
		end
		if (out_ld)
			noise_q <= noise_d;
	end

	// table write happens as the write item leaves stage 3
	assign tab_we = vld_s3 && (act_s3 == ACT_WRITE) && ctl.ld[4];

	gn2d_gtab #(.DEPTH(DEPTH), .AW(AW), .DW(GW)) u_gtab_r0 (
		.clk    (clk),
		.we     (tab_we),
		.waddr  (a00_s3),
		.wdata  (gw_s3),
		.re     (ctl.ld[4]),
		.raddr0 (a00_s3),
		.raddr1 (a10_s3),
		.rdata0 (g00),
		.rdata1 (g10)
	);

	gn2d_gtab #(.DEPTH(DEPTH), .AW(AW), .DW(GW)) u_gtab_r1 (
		.clk    (clk),
		.we     (tab_we),
		.waddr  (a00_s3),
		.wdata  (gw_s3),
		.re     (ctl.ld[4]),
		.raddr0 (a01_s3),
		.raddr1 (a11_s3),
		.rdata0 (g01),
		.rdata1 (g11)
	);

	gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
		.clk (clk),
		.ctl (ctl),
		.f   (fx_s1),
		.u   (u)
	);

	gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
		.clk (clk),
		.ctl (ctl),
		.f   (fy_s1),
		.u   (v)
	);

	gn2d_corner #(.FRAC_BITS(FRAC_BITS), .GRAD_BITS(GRAD_BITS)) u_corner_00 (
		.clk (clk), .ctl (ctl), .grad (g00), .ox (ox0), .oy (oy0), .dot (d0)
	);

	gn2d_corner #(.FRAC_BITS(FRAC_BITS), .GRAD_BITS(GRAD_BITS)) u_corner_10 (
		.clk (clk), .ctl (ctl), .grad (g10), .ox (ox1), .oy (oy0), .dot (d1)
	);

	gn2d_corner #(.FRAC_BITS(FRAC_BITS), .GRAD_BITS(GRAD_BITS)) u_corner_01 (
		.clk (clk), .ctl (ctl), .grad (g01), .ox (ox0), .oy (oy1), .dot (d2)
	);

	gn2d_corner #(.FRAC_BITS(FRAC_BITS), .GRAD_BITS(GRAD_BITS)) u_corner_11 (
		.clk (clk), .ctl (ctl), .grad (g11), .ox (ox1), .oy (oy1), .dot (d3)
	);

	gn2d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk (clk),
		.ctl (ctl),
		.d0  (d0),
		.d1  (d1),
		.d2  (d2),
		.d3  (d3),
		.u   (u),
		.v   (v),
		.n   (n_s10)
	);

	// Q.30 to Q1.15, round half up, saturate
	always_comb begin
		n_rnd = RW'(n_s10) + RND;
		n_sh  = n_rnd >>> ROUND_SH;
		if (n_sh > SAT_HI)
			noise_d = OUT_W'(SAT_HI);
		else if (n_sh < SAT_LO)
			noise_d = OUT_W'(SAT_LO);
		else
			noise_d = OUT_W'(n_sh);
	end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the 2D gradient noise evaluator: directed table, then random traffic.
module tb_top;
	import gn2d_pkg::*;

	localparam int RAND_ITEMS = 1100;
	localparam int HOLD_AT = 400;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 40;
	localparam int FQ = 16;
	localparam logic [15:0] G_POS = 16'h4000;
	localparam logic [15:0] G_NEG = 16'hC000;
	localparam logic [15:0] NOISE_MAX = 16'h7FFF;
	localparam logic [15:0] NOISE_MIN = 16'h8000;

	typedef struct packed {
		logic        act;
		logic [7:0]  cx;
		logic [7:0]  cy;
		logic [15:0] fx;
		logic [15:0] fy;
		logic [15:0] gx;
		logic [15:0] gy;
		bit          typed;
		logic [15:0] want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;

	// predictor state: gradient table copy and the cells whose four corners are loaded
	shortint grad_tab_x [0:65535];
	shortint grad_tab_y [0:65535];
	int unsigned eval_cells[$];

	logic [15:0] pending_noise[$];
	stim_row_t   dir_rows[$];
	int          accepted_cnt;
	int          total_items;
	int          err_cnt;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          hold_left;
	bit          hold_done;

	gradient_noise_2d_eval uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint mul_q16(longint a, longint b);
		return (a * b) >>> FQ;
	endfunction

	function automatic longint fade_q16(longint f);
		longint one;
		longint w;
		one = longint'(1) << FQ;
		w = FADE_C5 * f - FADE_C4 * one;
		w = mul_q16(w, f) + FADE_C3 * one;
		for (int k = 0; k < 3; k++)
			w = mul_q16(w, f);
		if (w < 0)
			w = 0;
		if (w > one)
			w = one;
		return w;
	endfunction

	// products already land in Q.30 at these widths, no shift needed
	function automatic longint corner_dot(logic [7:0] c, logic [7:0] r, longint ox, longint oy);
		return longint'(grad_tab_x[{r, c}]) * ox + longint'(grad_tab_y[{r, c}]) * oy;
	endfunction

	function automatic logic [15:0] predict_noise(logic [7:0] cx, logic [7:0] cy,
			logic [15:0] fx_in, logic [15:0] fy_in);
		logic [7:0] cx1;
		logic [7:0] cy1;
		longint one, fx, fy, u, v, d0, d1, d2, d3, a, b, n, r;
		cx1 = cx + 8'd1;
		cy1 = cy + 8'd1;
		one = longint'(1) << FQ;
		fx = longint'(fx_in);
		fy = longint'(fy_in);
		d0 = corner_dot(cx, cy, fx, fy);
		d1 = corner_dot(cx1, cy, fx - one, fy);
		d2 = corner_dot(cx, cy1, fx, fy - one);
		d3 = corner_dot(cx1, cy1, fx - one, fy - one);
		u = fade_q16(fx);
		v = fade_q16(fy);
		a = d0 + mul_q16(d1 - d0, u);
		b = d2 + mul_q16(d3 - d2, u);
		n = a + mul_q16(b - a, v);
		r = (n + (longint'(1) << (DOT_FRAC - 16))) >>> ROUND_SH;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	function automatic stim_row_t mk_row(logic act, logic [7:0] cx, logic [7:0] cy,
			logic [15:0] fx, logic [15:0] fy, logic [15:0] gx, logic [15:0] gy,
			bit typed, logic [15:0] want);
		stim_row_t t;
		t.act = act;
		t.cx = cx;
		t.cy = cy;
		t.fx = fx;
		t.fy = fy;
		t.gx = gx;
		t.gy = gy;
		t.typed = typed;
		t.want = want;
		return t;
	endfunction

	function automatic logic [15:0] rand_frac();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_grad();
		case ($urandom_range(0, 9))
			0: return G_POS;
			1: return G_NEG;
			2: return 16'h0000;
			default: return 16'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	// offers one item from a falling edge, returns at the falling edge after its transfer
	task automatic send_item(stim_row_t t);
		logic [S_TDATA_W-1:0] d;
		logic [15:0] idx;
		d = '0;
		d[CX_LSB +: CELL_W] = t.cx;
		d[CY_LSB +: CELL_W] = t.cy;
		d[FX_LSB +: FIELD_W] = t.fx;
		d[FY_LSB +: FIELD_W] = t.fy;
		d[GX_LSB +: FIELD_W] = t.gx;
		d[GY_LSB +: FIELD_W] = t.gy;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= t.act;
		s_tdata <= d;
		do
			@(posedge clk);
		while (!s_tready);
		idx = {t.cy, t.cx};
		if (t.act == ACT_WRITE) begin
			grad_tab_x[idx] = shortint'(t.gx);
			grad_tab_y[idx] = shortint'(t.gy);
		end else begin
			pending_noise.push_back(t.typed ? t.want : predict_noise(t.cx, t.cy, t.fx, t.fy));
		end
		accepted_cnt++;
		if (accepted_cnt < total_items / 3) begin
			tx_idle_pct = 15;
			rx_idle_pct = 48;
		end else if (accepted_cnt < 2 * total_items / 3) begin
			tx_idle_pct = 48;
			rx_idle_pct = 15;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		@(negedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off to back the pipeline up
	initial begin
		m_tready = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_noise.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("ERROR: unexpected noise transfer %0d", $signed(m_tdata));
			end else begin
				want = pending_noise.pop_front();
				if (m_tdata !== want) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("ERROR: noise expected %0d got %0d", $signed(want),
							$signed(m_tdata));
				end
			end
		end
	end

	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		stim_row_t   t;
		int unsigned cell_pick;
		int          pick;
		logic [7:0]  cx, cy;
		s_tvalid = 1'b0;
		s_tuser = ACT_WRITE;
		s_tdata = '0;
		arst_n = 1'b0;
		accepted_cnt = 0;
		err_cnt = 0;
		tx_idle_pct = 15;
		rx_idle_pct = 48;

		// cell (255,255) wraps onto column 0 and row 0; corners point at the center
		dir_rows.push_back(mk_row(ACT_WRITE, 8'd255, 8'd255, 16'h0, 16'h0, G_POS, G_POS, 0, 0));
		dir_rows.push_back(mk_row(ACT_WRITE, 8'd0, 8'd255, 16'h0, 16'h0, G_NEG, G_POS, 0, 0));
		dir_rows.push_back(mk_row(ACT_WRITE, 8'd255, 8'd0, 16'hFFFF, 16'hFFFF, G_POS, G_NEG, 0, 0));
		dir_rows.push_back(mk_row(ACT_WRITE, 8'd0, 8'd0, 16'hFFFF, 16'h0, G_NEG, G_NEG, 0, 0));
		dir_rows.push_back(mk_row(ACT_EVAL, 8'd255, 8'd255, 16'h8000, 16'h8000, 16'h0, 16'h0,
			1, NOISE_MAX));
		dir_rows.push_back(mk_row(ACT_EVAL, 8'd255, 8'd255, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF,
			1, 16'h0));
		dir_rows.push_back(mk_row(ACT_EVAL, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0,
			0, 0));
		dir_rows.push_back(mk_row(ACT_EVAL, 8'd255, 8'd255, 16'hFFFF, 16'h0, 16'h0, 16'h0, 0, 0));
		dir_rows.push_back(mk_row(ACT_EVAL, 8'd255, 8'd255, 16'h0, 16'hFFFF, 16'h0, 16'h0, 0, 0));
		// same cell with every gradient flipped: negative saturation
		dir_rows.push_back(mk_row(ACT_WRITE, 8'd255, 8'd255, 16'h0, 16'h0, G_NEG, G_NEG, 0, 0));
		dir_rows.push_back(mk_row(ACT_WRITE, 8'd0, 8'd255, 16'h0, 16'h0, G_POS, G_NEG, 0, 0));
		dir_rows.push_back(mk_row(ACT_WRITE, 8'd255, 8'd0, 16'h0, 16'h0, G_NEG, G_POS, 0, 0));
		dir_rows.push_back(mk_row(ACT_WRITE, 8'd0, 8'd0, 16'h0, 16'h0, G_POS, G_POS, 0, 0));
		dir_rows.push_back(mk_row(ACT_EVAL, 8'd255, 8'd255, 16'h8000, 16'h8000, 16'h0, 16'h0,
			1, NOISE_MIN));
		dir_rows.push_back(mk_row(ACT_EVAL, 8'd255, 8'd255, 16'h4000, 16'hC000, 16'h0, 16'h0,
			0, 0));
		dir_rows.push_back(mk_row(ACT_WRITE, 8'd1, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0, 0, 0));
		dir_rows.push_back(mk_row(ACT_WRITE, 8'd0, 8'd1, 16'h0, 16'h0, 16'h3FFF, 16'hC001, 0, 0));
		dir_rows.push_back(mk_row(ACT_WRITE, 8'd1, 8'd1, 16'h0, 16'h0, 16'hFFFF, 16'h0001, 0, 0));
		dir_rows.push_back(mk_row(ACT_EVAL, 8'd0, 8'd0, 16'h1234, 16'hABCD, 16'h0, 16'h0, 0, 0));
		dir_rows.push_back(mk_row(ACT_EVAL, 8'd0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0, 1, 16'h0));
		dir_rows.push_back(mk_row(ACT_EVAL, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 0, 0));
		dir_rows.push_back(mk_row(ACT_EVAL, 8'd0, 8'd0, 16'h0001, 16'hFFFE, 16'h0, 16'h0, 0, 0));
		total_items = dir_rows.size() + RAND_ITEMS;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i]);
		eval_cells.push_back({8'd255, 8'd255});
		eval_cells.push_back({8'd0, 8'd0});

		// random: mostly evaluates of fully loaded cells, with 2x2 block loads and rewrites
		while (accepted_cnt < total_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				cx = 8'($urandom);
				cy = 8'($urandom);
				for (int k = 0; k < 4; k++) begin
					t = mk_row(ACT_WRITE, cx + 8'(k % 2), cy + 8'(k / 2), 16'($urandom),
						16'($urandom), rand_grad(), rand_grad(), 0, 0);
					send_item(t);
				end
				eval_cells.push_back({cy, cx});
			end else if (pick < 25) begin
				cell_pick = eval_cells[$urandom_range(0, eval_cells.size() - 1)];
				t = mk_row(ACT_WRITE, cell_pick[7:0] + 8'($urandom_range(0, 1)),
					cell_pick[15:8] + 8'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
					rand_grad(), rand_grad(), 0, 0);
				send_item(t);
			end else begin
				cell_pick = eval_cells[$urandom_range(0, eval_cells.size() - 1)];
				t = mk_row(ACT_EVAL, cell_pick[7:0], cell_pick[15:8], rand_frac(), rand_frac(),
					16'($urandom), 16'($urandom), 0, 0);
				send_item(t);
			end
		end
		s_tvalid <= 1'b0;

		while (pending_noise.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && pending_noise.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
